// ===== rtl/uab_pkg.sv =====
// Package of types and constants for the UART autobaud bit timer.
`default_nettype none

package uab_pkg;

    // Width of the tick timer that measures the high pulse.
    localparam int TIMER_WIDTH = 8;

    // Field widths of the beats and registers.
    localparam int BIT_TIME_WIDTH = 8;
    localparam int OFFSET_WIDTH   = 9;
    localparam int LIMIT_WIDTH    = 5;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 9;

    // Register reset values.
    localparam logic [BIT_TIME_WIDTH-1:0] RST_BIT_TIME     = 8'd100;
    localparam logic [OFFSET_WIDTH-1:0]   RST_SAMPLE_OFFSET = 9'd150;
    localparam logic [LIMIT_WIDTH-1:0]    RST_FIRST_LIMIT   = 5'd10;
    localparam logic [LIMIT_WIDTH-1:0]    RST_SECOND_LIMIT  = 5'd30;

    // Configuration register indexes.
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEFAULT_BIT_TIME      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEFAULT_SAMPLE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIRST_WAIT_LIMIT      = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SECOND_WAIT_LIMIT     = 2'd3;

    // Operation codes of an input beat.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_TRAINED  = 2'd1,
        ST_TIMEOUT  = 2'd2,
        ST_MEAS_OVF = 2'd3
    } status_t;

    typedef struct packed {
        logic operation;
        logic line_level;
    } uab_in_t;

    typedef struct packed {
        status_t                   status;
        logic [BIT_TIME_WIDTH-1:0] bit_time;
        logic [OFFSET_WIDTH-1:0]   sample_offset;
    } uab_out_t;

endpackage

`default_nettype wire

// ===== rtl/uart_autobaud_bit_timer_top.sv =====
// Top level of the UART autobaud bit timer: training sequencer and result register.
//
//  Channel   Signals                              Direction  Payload
//  in        in_valid, in_ready, in_data          into block uab_in_t (operation, line_level)
//  out       out_valid, out_ready, out_data       out        uab_out_t (status, bit_time,
//                                                            sample_offset)
//  cfg       cfg_write_en, cfg_index, cfg_data    into block register write, no read-back
//
// The training state is updated and the result registered at the edge that accepts
// a beat, so a new beat can be taken every cycle unless a full result register stalls.
// The result register holds one result; the input is taken whenever that register is
// empty or is being emptied in the same cycle.
// Reset clears the state machine, the timer and the wrap count, and loads the reset
// values of the configuration and working registers.
`default_nettype none

module uart_autobaud_bit_timer_top
    import uab_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire uab_in_t                   in_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output uab_out_t                       out_data,
    input  wire logic                      cfg_write_en,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    // Width wide enough to compare the timer against the largest bit time.
    localparam int EXT_WIDTH = (TIMER_WIDTH > BIT_TIME_WIDTH) ? TIMER_WIDTH : BIT_TIME_WIDTH;
    localparam logic [EXT_WIDTH-1:0] BIT_TIME_MAX = EXT_WIDTH'({BIT_TIME_WIDTH{1'b1}});

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_WAIT_HIGH = 4'b0010,
        PH_WAIT_LOW  = 4'b0100,
        PH_MEASURE   = 4'b1000
    } phase_t;

    logic [BIT_TIME_WIDTH-1:0] default_bit_time_reg;
    logic [OFFSET_WIDTH-1:0]   default_offset_reg;
    logic [LIMIT_WIDTH-1:0]    first_limit_reg;
    logic [LIMIT_WIDTH-1:0]    second_limit_reg;

    phase_t                    phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]    timer_reg, timer_next;
    logic [LIMIT_WIDTH-1:0]    wrap_count_reg, wrap_count_next;
    logic [BIT_TIME_WIDTH-1:0] bit_time_reg, bit_time_next;
    logic [OFFSET_WIDTH-1:0]   offset_reg, offset_next;
    status_t                   status_next;

    logic                      out_valid_reg;
    uab_out_t                  out_data_reg;

    logic                      in_fire;
    logic [TIMER_WIDTH-1:0]    timer_inc;
    logic                      timer_wrap;
    logic [LIMIT_WIDTH-1:0]    wrap_count_inc;
    logic [LIMIT_WIDTH-1:0]    wait_limit;
    logic [EXT_WIDTH-1:0]      timer_ext;
    logic [BIT_TIME_WIDTH-1:0] measured;

    // Handshake: the result register is free or is being emptied.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_bit_time_reg <= RST_BIT_TIME;
            default_offset_reg   <= RST_SAMPLE_OFFSET;
            first_limit_reg      <= RST_FIRST_LIMIT;
            second_limit_reg     <= RST_SECOND_LIMIT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_BIT_TIME:      default_bit_time_reg <= cfg_data[BIT_TIME_WIDTH-1:0];
                CFG_DEFAULT_SAMPLE_OFFSET: default_offset_reg   <= cfg_data[OFFSET_WIDTH-1:0];
                CFG_FIRST_WAIT_LIMIT:      first_limit_reg      <= cfg_data[LIMIT_WIDTH-1:0];
                CFG_SECOND_WAIT_LIMIT:     second_limit_reg     <= cfg_data[LIMIT_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Timer and wrap count increments, and the limit that applies to this tick.
    assign timer_inc      = timer_reg + TIMER_WIDTH'(1);
    assign timer_wrap     = (timer_inc == '0);
    assign wrap_count_inc = wrap_count_reg + LIMIT_WIDTH'(1);
    assign wait_limit     = (phase_reg == PH_WAIT_HIGH && in_data.line_level) ?
                            first_limit_reg : second_limit_reg;

    // The measured pulse saturates at the largest bit time.
    assign timer_ext = EXT_WIDTH'(timer_reg);
    assign measured  = (timer_ext > BIT_TIME_MAX) ? BIT_TIME_WIDTH'(BIT_TIME_MAX)
                                                  : timer_ext[BIT_TIME_WIDTH-1:0];

    // Training sequencer: next state and status for the beat on the input.
    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        wrap_count_next = wrap_count_reg;
        bit_time_next   = bit_time_reg;
        offset_next     = offset_reg;
        status_next     = ST_BUSY;

        if (in_data.operation == OP_START)
        begin
            bit_time_next   = default_bit_time_reg;
            offset_next     = default_offset_reg;
            timer_next      = '0;
            wrap_count_next = '0;
            phase_next      = PH_WAIT_HIGH;
        end
        else
        begin
            unique case (phase_reg) inside
                PH_IDLE:
                begin
                end
                PH_WAIT_HIGH, PH_WAIT_LOW:
                begin
                    if (in_data.line_level && phase_reg == PH_WAIT_LOW)
                    begin
                        // Rising edge: restart the timer and count this tick.
                        timer_next = TIMER_WIDTH'(1);
                        phase_next = PH_MEASURE;
                    end
                    else
                    begin
                        // A low sample while waiting for high moves on in the same tick.
                        if (!in_data.line_level)
                        begin
                            phase_next = PH_WAIT_LOW;
                        end
                        timer_next = timer_inc;
                        if (timer_wrap)
                        begin
                            wrap_count_next = wrap_count_inc;
                            if (wrap_count_inc == wait_limit)
                            begin
                                phase_next  = PH_IDLE;
                                status_next = ST_TIMEOUT;
                            end
                        end
                    end
                end
                PH_MEASURE:
                begin
                    if (in_data.line_level)
                    begin
                        timer_next = timer_inc;
                        if (timer_wrap)
                        begin
                            phase_next  = PH_IDLE;
                            status_next = ST_MEAS_OVF;
                        end
                    end
                    else
                    begin
                        // Falling edge: store the bit time and one and a half bit times.
                        bit_time_next = measured;
                        offset_next   = {1'b0, measured} + OFFSET_WIDTH'(measured >> 1);
                        phase_next    = PH_IDLE;
                        status_next   = ST_TRAINED;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Training state, updated once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            wrap_count_reg <= '0;
            bit_time_reg   <= RST_BIT_TIME;
            offset_reg     <= RST_SAMPLE_OFFSET;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            wrap_count_reg <= wrap_count_next;
            bit_time_reg   <= bit_time_next;
            offset_reg     <= offset_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg.status        <= status_next;
            out_data_reg.bit_time      <= bit_time_next;
            out_data_reg.sample_offset <= offset_next;
        end
    end

    // Every accepted beat leaves a result waiting.
    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted beat left no result");

    // A finished training leaves the sequencer idle.
    a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && status_next != ST_BUSY |=> phase_reg == PH_IDLE)
        else $error("training finished but sequencer not idle");

    // A trained result carries one and a half bit times as its sample offset.
    a_trained_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status == ST_TRAINED |->
        out_data_reg.sample_offset ==
        ({1'b0, out_data_reg.bit_time} + OFFSET_WIDTH'(out_data_reg.bit_time >> 1)))
        else $error("trained sample offset does not match bit time");

endmodule

`default_nettype wire

// ===== test/uart_autobaud_bit_timer_top_tb.sv =====
// Testbench for the UART autobaud bit timer: directed and random training runs against a predictor.
`timescale 1ns / 1ps

module uart_autobaud_bit_timer_top_tb;
    import uab_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int MAX_GAP     = 10;
    localparam int BEAT_TARGET = 1900;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 60;

    typedef enum logic [1:0] {
        TRN_IDLE,
        TRN_WAIT_HIGH,
        TRN_WAIT_LOW,
        TRN_MEASURE
    } trn_phase_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    uab_in_t                   in_data;
    logic                      out_valid;
    logic                      out_ready;
    uab_out_t                  out_data;
    logic                      cfg_write_en;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    // Predictor copy of the configuration registers.
    logic [BIT_TIME_WIDTH-1:0] cfg_bit_time;
    logic [OFFSET_WIDTH-1:0]   cfg_offset;
    logic [LIMIT_WIDTH-1:0]    cfg_first;
    logic [LIMIT_WIDTH-1:0]    cfg_second;

    // Predictor copy of the training state.
    trn_phase_t                trn_phase;
    logic [TIMER_WIDTH-1:0]    tick_count;
    logic [LIMIT_WIDTH-1:0]    wrap_count;
    logic [BIT_TIME_WIDTH-1:0] bit_time_q;
    logic [OFFSET_WIDTH-1:0]   offset_q;

    uab_out_t timing_q[$];

    int  errors;
    int  beats_sent;
    int  results_seen;
    int  trained_seen;
    int  timeouts_seen;
    int  overflows_seen;
    int  holds_done;
    int  hold_cycles;
    int  cycle_count;
    bit  no_gaps;

    uart_autobaud_bit_timer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("uart_autobaud_bit_timer_top_tb: FAIL");
            $finish;
        end
    end

    // Number of idle cycles before the next beat on either side.
    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Works out the result of one accepted beat and advances the training state.
    function automatic uab_out_t predict_timing(uab_in_t beat);
        uab_out_t               res;
        logic [TIMER_WIDTH-1:0] measured;
        res.status = ST_BUSY;
        if (beat.operation == OP_START)
        begin
            bit_time_q = cfg_bit_time;
            offset_q   = cfg_offset;
            tick_count = '0;
            wrap_count = '0;
            trn_phase  = TRN_WAIT_HIGH;
        end
        else
        begin
            // Waiting for the idle high level to end; a low sample falls through.
            if (trn_phase == TRN_WAIT_HIGH)
            begin
                if (beat.line_level)
                begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count == '0)
                    begin
                        wrap_count = wrap_count + 1'b1;
                        if (wrap_count == cfg_first)
                        begin
                            trn_phase  = TRN_IDLE;
                            res.status = ST_TIMEOUT;
                        end
                    end
                end
                else
                begin
                    trn_phase = TRN_WAIT_LOW;
                end
            end
            // Waiting for the low level to end; the rising edge starts the measurement.
            if (trn_phase == TRN_WAIT_LOW)
            begin
                if (!beat.line_level)
                begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count == '0)
                    begin
                        wrap_count = wrap_count + 1'b1;
                        if (wrap_count == cfg_second)
                        begin
                            trn_phase  = TRN_IDLE;
                            res.status = ST_TIMEOUT;
                        end
                    end
                end
                else
                begin
                    tick_count = TIMER_WIDTH'(1);
                    trn_phase  = TRN_MEASURE;
                end
            end
            else if (trn_phase == TRN_MEASURE)
            begin
                if (beat.line_level)
                begin
                    tick_count = tick_count + 1'b1;
                    if (tick_count == '0)
                    begin
                        trn_phase  = TRN_IDLE;
                        res.status = ST_MEAS_OVF;
                    end
                end
                else
                begin
                    measured   = tick_count;
                    bit_time_q = (measured > 255) ? 8'd255 : BIT_TIME_WIDTH'(measured);
                    offset_q   = {1'b0, bit_time_q} + (bit_time_q >> 1);
                    trn_phase  = TRN_IDLE;
                    res.status = ST_TRAINED;
                end
            end
        end
        res.bit_time      = bit_time_q;
        res.sample_offset = offset_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Offers one beat and records its expected result once accepted.
    task automatic send_beat(input logic op, input logic line);
        int      gap;
        uab_in_t beat;
        beat.operation  = op;
        beat.line_level = line;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        timing_q.push_back(predict_timing(in_data));
        beats_sent++;
        @(negedge clk);
    endtask

    // Stops offering beats and waits until every expected result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (timing_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] value);
        drain_results();
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            CFG_DEFAULT_BIT_TIME:      cfg_bit_time = value[BIT_TIME_WIDTH-1:0];
            CFG_DEFAULT_SAMPLE_OFFSET: cfg_offset   = value[OFFSET_WIDTH-1:0];
            CFG_FIRST_WAIT_LIMIT:      cfg_first    = value[LIMIT_WIDTH-1:0];
            CFG_SECOND_WAIT_LIMIT:     cfg_second   = value[LIMIT_WIDTH-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // One training attempt: start, idle high, low, high pulse and optionally the closing low.
    task automatic run_training(input int lead, input int low, input int pulse, input bit close);
        send_beat(OP_START, 1'($urandom_range(0, 1)));
        repeat (lead) send_beat(OP_TICK, 1'b1);
        repeat (low) send_beat(OP_TICK, 1'b0);
        repeat (pulse) send_beat(OP_TICK, 1'b1);
        if (close)
            send_beat(OP_TICK, 1'b0);
    endtask

    // Receiver: random stalls, occasionally one long hold-off.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
                holds_done++;
            end
            else
            begin
                gap = draw_gap();
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Compares each result beat with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        uab_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (timing_q.size() == 0)
            begin
                report_mismatch("unexpected result beat", int'(out_data), 0);
            end
            else
            begin
                want = timing_q.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", out_data.status, want.status);
                if (out_data.bit_time !== want.bit_time)
                    report_mismatch("bit_time", out_data.bit_time, want.bit_time);
                if (out_data.sample_offset !== want.sample_offset)
                    report_mismatch("sample_offset", out_data.sample_offset, want.sample_offset);
            end
            case (out_data.status)
                ST_TRAINED:  trained_seen++;
                ST_TIMEOUT:  timeouts_seen++;
                ST_MEAS_OVF: overflows_seen++;
                default: ;
            endcase
        end
    end

    // Idle ticks after reset, then a short successful training.
    task automatic test_reset_defaults();
        send_beat(OP_TICK, 1'b1);
        send_beat(OP_TICK, 1'b0);
        run_training(2, 2, 1, 1'b1);
        send_beat(OP_TICK, 1'b1);
    endtask

    // Register extremes, including a sample offset beyond its nominal range.
    task automatic test_config_extremes();
        write_reg(CFG_DEFAULT_BIT_TIME, 9'h100);
        write_reg(CFG_DEFAULT_SAMPLE_OFFSET, 9'd0);
        write_reg(CFG_FIRST_WAIT_LIMIT, 9'd31);
        write_reg(CFG_SECOND_WAIT_LIMIT, 9'd31);
        run_training(1, 1, 3, 1'b0);
        send_beat(OP_TICK, 1'b0);
        write_reg(CFG_DEFAULT_BIT_TIME, 9'd255);
        write_reg(CFG_DEFAULT_SAMPLE_OFFSET, 9'd511);
        send_beat(OP_START, 1'b0);
        send_beat(OP_TICK, 1'b1);
    endtask

    // Shortest and longest measurable pulses, and a low first sample.
    task automatic test_bit_time_extremes();
        run_training(0, 1, 255, 1'b1);
        run_training(3, 3, 2, 1'b1);
        run_training(0, 2, 1, 1'b1);
    endtask

    // A start in the middle of training begins again from the start.
    task automatic test_restart_mid_training();
        send_beat(OP_START, 1'b1);
        send_beat(OP_TICK, 1'b1);
        send_beat(OP_TICK, 1'b0);
        send_beat(OP_TICK, 1'b1);
        run_training(1, 1, 4, 1'b1);
    endtask

    // Timeouts in the wait for low and in the wait for high.
    task automatic test_wait_timeouts();
        write_reg(CFG_FIRST_WAIT_LIMIT, 9'd1);
        write_reg(CFG_SECOND_WAIT_LIMIT, 9'd31);
        run_training(256, 0, 0, 1'b0);
        send_beat(OP_TICK, 1'b0);
        // The count is cumulative: one wrap while high, the second while low.
        write_reg(CFG_FIRST_WAIT_LIMIT, 9'd2);
        write_reg(CFG_SECOND_WAIT_LIMIT, 9'd2);
        run_training(300, 212, 0, 1'b0);
        send_beat(OP_TICK, 1'b1);
    endtask

    // A high pulse longer than the timer can count.
    task automatic test_measure_overflow();
        write_reg(CFG_FIRST_WAIT_LIMIT, 9'd10);
        write_reg(CFG_SECOND_WAIT_LIMIT, 9'd30);
        write_reg(CFG_DEFAULT_BIT_TIME, 9'd100);
        write_reg(CFG_DEFAULT_SAMPLE_OFFSET, 9'd150);
        run_training(1, 1, 256, 1'b1);
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_output_backpressure();
        hold_cycles = LONG_HOLD;
        no_gaps = 1'b1;
        run_training(2, 3, 20, 1'b1);
        repeat (10) send_beat(OP_TICK, 1'($urandom_range(0, 1)));
        no_gaps = 1'b0;
        drain_results();
    endtask

    // Mostly well-formed trainings with random lengths, plus noise and broken sequences.
    task automatic test_random_traffic();
        int pick;
        int seqs;
        int pulse;
        seqs = 0;
        while (beats_sent < BEAT_TARGET)
        begin
            if (seqs % 16 == 15)
            begin
                write_reg(CFG_DEFAULT_BIT_TIME, 9'($urandom_range(0, 511)));
                write_reg(CFG_DEFAULT_SAMPLE_OFFSET, 9'($urandom_range(0, 511)));
                write_reg(CFG_FIRST_WAIT_LIMIT,
                          ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 31)));
                write_reg(CFG_SECOND_WAIT_LIMIT,
                          ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 31)));
            end
            if (seqs % 10 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // Mostly short pulses, a few long ones up to and past the wrap.
                pulse = $urandom_range(0, 99);
                if (pulse < 85)
                    pulse = $urandom_range(1, 20);
                else if (pulse < 95)
                    pulse = $urandom_range(21, 254);
                else
                    pulse = $urandom_range(255, 257);
                run_training($urandom_range(0, 6), $urandom_range(1, 6), pulse,
                             $urandom_range(0, 9) != 0);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                send_beat(OP_START, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 8)) send_beat(OP_TICK, 1'($urandom_range(0, 1)));
            end
            seqs++;
        end
        no_gaps = 1'b0;
        drain_results();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        hold_cycles  = 0;
        cfg_bit_time = RST_BIT_TIME;
        cfg_offset   = RST_SAMPLE_OFFSET;
        cfg_first    = RST_FIRST_LIMIT;
        cfg_second   = RST_SECOND_LIMIT;
        trn_phase    = TRN_IDLE;
        tick_count   = '0;
        wrap_count   = '0;
        bit_time_q   = RST_BIT_TIME;
        offset_q     = RST_SAMPLE_OFFSET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_config_extremes();
        test_bit_time_extremes();
        test_restart_mid_training();
        test_wait_timeouts();
        test_measure_overflow();
        test_output_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        $display("Run covered %0d input beats and %0d result beats with %0d long output holds.",
                 beats_sent, results_seen, holds_done);
        $display("Outcomes seen: %0d trained, %0d wait timeouts, %0d measurement overflows.",
                 trained_seen, timeouts_seen, overflows_seen);
        if (errors == 0)
            $display("uart_autobaud_bit_timer_top_tb: PASS");
        else
            $display("uart_autobaud_bit_timer_top_tb: FAIL");
        $finish;
    end

endmodule
